// ----- hdl/cobs_frame_decoder_top_defines.svh -----
// Assertion helpers shared by the decoder RTL.
// Both expect signals named clk and rst in the module that uses them.
`ifndef COBS_FRAME_DECODER_TOP_DEFINES_SVH
`define COBS_FRAME_DECODER_TOP_DEFINES_SVH

// Condition holds at every edge outside reset
`define CFD_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cobsd_pkg.sv -----
package cobsd_pkg;

  // Default geometry of the packet buffer ring
  localparam int DEF_BUF_BYTES = 256;
  localparam int DEF_NUM_SLOTS = 4;

  // Field widths of the stream items
  localparam int KIND_W   = 3;
  localparam int SLOT_W_O = 2;
  localparam int POS_W    = 9;
  localparam int BYTE_W   = 8;
  localparam int DROP_W   = 32;
  localparam int LEN_W    = 9;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;

  localparam logic [LEN_W-1:0] MIN_LEN_RST = 9'd1;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 9'd256;

  // COBS special bytes
  localparam logic [BYTE_W-1:0] CODE_RESTART = 8'hff;
  localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;

  // Result queue depth
  localparam int QDEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE    = 3'd0,
    KIND_COMMIT  = 3'd1,
    KIND_DROP    = 3'd2,
    KIND_BAD_LEN = 3'd3,
    KIND_GARBAGE = 3'd4,
    KIND_OVERRUN = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W_O-1:0] slot;
    logic [POS_W-1:0]    position;
    logic [BYTE_W-1:0]   data;
    logic [DROP_W-1:0]   drop_count;
    logic                last;
  } res_t;

  // Up to two results produced by one input byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

// ----- hdl/cobsd_step.sv -----
module cobsd_step #(
  parameter int BUF_BYTES = cobsd_pkg::DEF_BUF_BYTES,
  parameter int NUM_SLOTS = cobsd_pkg::DEF_NUM_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cobsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cobsd_pkg::LEN_W-1:0]        cfg_data,
  input  logic                               in_fire,
  input  logic [cobsd_pkg::BYTE_W-1:0]       rx_byte,
  input  logic                               queue_has_room,
  output cobsd_pkg::step_out_t               step_out
);
  import cobsd_pkg::*;

  localparam int WP_W   = $clog2(BUF_BYTES + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CMP_W  = (WP_W > LEN_W) ? WP_W : LEN_W;

  logic [LEN_W-1:0]  min_frame_len;
  logic [LEN_W-1:0]  max_frame_len;
  logic [BYTE_W-1:0] code_value, code_value_next;
  logic [BYTE_W-1:0] block_left, block_left_next;
  logic [WP_W-1:0]   write_pos, write_pos_next;
  logic [SLOT_W-1:0] current_slot, current_slot_next;
  logic [DROP_W-1:0] dropped_frames, dropped_frames_next;

  logic              ovr, implied, len_ok;
  logic [BYTE_W-1:0] code_e, bl_e;
  logic [WP_W-1:0]   wp_e;
  logic              e0_v, e1_v;
  kind_t             e0_kind, e1_kind;
  logic [POS_W-1:0]  e0_pos, e1_pos;
  logic [BYTE_W-1:0] e0_data;
  res_t              e0, e1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_len <= MIN_LEN_RST;
      max_frame_len <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LEN: min_frame_len <= cfg_data;
        REG_MAX_LEN: max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode one byte: overrun check, then block body or code byte
  always_comb begin
    ovr     = (write_pos == WP_W'(BUF_BYTES)) && (rx_byte != BYTE_ZERO);
    code_e  = ovr ? CODE_RESTART : code_value;
    bl_e    = ovr ? BYTE_ZERO : block_left;
    wp_e    = ovr ? '0 : write_pos;
    implied = (bl_e == BYTE_ZERO) && (code_e != CODE_RESTART);
    len_ok  = (CMP_W'(wp_e) >= CMP_W'(min_frame_len)) &&
              (CMP_W'(wp_e) <= CMP_W'(max_frame_len));

    code_value_next     = code_value;
    block_left_next     = block_left;
    write_pos_next      = write_pos;
    current_slot_next   = current_slot;
    dropped_frames_next = dropped_frames;

    e0_v    = 1'b0;
    e0_kind = KIND_BYTE;
    e0_pos  = POS_W'(wp_e);
    e0_data = BYTE_ZERO;
    e1_v    = 1'b0;
    e1_kind = KIND_BYTE;
    e1_pos  = POS_W'(wp_e);

    // Full buffer and a non-zero byte: restart before decoding it
    if (ovr) begin
      e0_v    = 1'b1;
      e0_kind = KIND_OVERRUN;
      e0_pos  = POS_W'(write_pos);
    end

    if (bl_e != BYTE_ZERO) begin
      if (rx_byte == BYTE_ZERO) begin
        // zero inside a block
        e0_v            = 1'b1;
        e0_kind         = KIND_GARBAGE;
        code_value_next = CODE_RESTART;
        block_left_next = BYTE_ZERO;
        write_pos_next  = '0;
      end else begin
        e0_v            = 1'b1;
        e0_data         = rx_byte;
        write_pos_next  = wp_e + WP_W'(1);
        block_left_next = bl_e - BYTE_W'(1);
      end
    end else begin
      // implied zero after a short block, stored only inside the buffer
      if (implied && (wp_e < WP_W'(BUF_BYTES))) begin
        e0_v = 1'b1;
      end
      if (rx_byte == BYTE_ZERO) begin
        // frame end; length excludes the implied zero, which is wp_e
        if (implied || (wp_e != '0)) begin
          e1_v = 1'b1;
          if (!len_ok) begin
            e1_kind = KIND_BAD_LEN;
          end else if (queue_has_room) begin
            e1_kind = KIND_COMMIT;
            current_slot_next = (current_slot == SLOT_W'(NUM_SLOTS - 1)) ?
                                '0 : current_slot + SLOT_W'(1);
          end else begin
            e1_kind = KIND_DROP;
            dropped_frames_next = dropped_frames + DROP_W'(1);
          end
        end
        code_value_next = CODE_RESTART;
        block_left_next = BYTE_ZERO;
        write_pos_next  = '0;
      end else begin
        code_value_next = rx_byte;
        block_left_next = rx_byte - BYTE_W'(1);
        write_pos_next  = wp_e + WP_W'(implied);
      end
    end
  end

  // Pack results, first one in r0
  always_comb begin
    e0.kind       = e0_kind;
    e0.slot       = SLOT_W_O'(current_slot);
    e0.position   = e0_pos;
    e0.data       = e0_data;
    e0.drop_count = dropped_frames_next;
    e0.last       = !e1_v;
    e1.kind       = e1_kind;
    e1.slot       = SLOT_W_O'(current_slot);
    e1.position   = e1_pos;
    e1.data       = BYTE_ZERO;
    e1.drop_count = dropped_frames_next;
    e1.last       = 1'b1;
    step_out.cnt  = {1'b0, e0_v} + {1'b0, e1_v};
    step_out.r0   = e0_v ? e0 : e1;
    step_out.r1   = e1;
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      code_value     <= CODE_RESTART;
      block_left     <= BYTE_ZERO;
      write_pos      <= '0;
      current_slot   <= '0;
      dropped_frames <= '0;
    end else if (in_fire) begin
      code_value     <= code_value_next;
      block_left     <= block_left_next;
      write_pos      <= write_pos_next;
      current_slot   <= current_slot_next;
      dropped_frames <= dropped_frames_next;
    end
  end

`include "cobs_frame_decoder_top_defines.svh"

  `CFD_ASSERT_NOW(a_wp_in_buf, write_pos <= WP_W'(BUF_BYTES), "write position past buffer end")
  `CFD_ASSERT_NOW(a_block_in_code, (block_left == BYTE_ZERO) || (block_left < code_value), "block count not below code")
  `CFD_ASSERT_NEXT(a_commit_slot, in_fire && e1_v && (e1_kind == KIND_COMMIT), current_slot != $past(current_slot), "slot did not advance on commit")
  `CFD_ASSERT_NEXT(a_drop_count, in_fire && e1_v && (e1_kind == KIND_DROP), dropped_frames == $past(dropped_frames) + DROP_W'(1), "drop counter missed a drop")

endmodule

// ----- hdl/cobsd_outq.sv -----
module cobsd_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  cobsd_pkg::step_out_t step_out,
  output logic                 space_ok,
  output logic                 m_valid,
  input  logic                 m_ready,
  output cobsd_pkg::res_t      m_res
);
  import cobsd_pkg::*;

  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic [QPTR_W-1:0] head_next, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [1:0]        push_cnt;
  logic              pop;

  assign push_cnt = in_fire ? step_out.cnt : 2'd0;
  assign pop      = m_valid && m_ready;
  assign m_valid  = (count != '0);
  assign m_res    = mem[head];
  // room for the largest burst of one item
  assign space_ok = (count <= CNT_W'(QDEPTH - 2));

  always_comb begin
    head_next  = pop ? head + QPTR_W'(1) : head;
    tail_next  = tail + QPTR_W'(push_cnt);
    count_next = count + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  // Payload store
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[tail] <= step_out.r0;
    end
    if (push_cnt == 2'd2) begin
      mem[tail + QPTR_W'(1)] <= step_out.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

`include "cobs_frame_decoder_top_defines.svh"

  `CFD_ASSERT_NOW(a_q_bound, count <= CNT_W'(QDEPTH), "result queue overfilled")
  `CFD_ASSERT_NOW(a_q_burst, (push_cnt != 2'd2) || (count <= CNT_W'(QDEPTH - 2)), "two results pushed without room")
  `CFD_ASSERT_NEXT(a_q_drain, pop && (push_cnt == 2'd0), count == $past(count) - CNT_W'(1), "fill level wrong after pop")

endmodule

// ----- hdl/cobs_frame_decoder_top.sv -----
// COBS frame decoder.
// Input stream (s_*): one raw link byte per item with a queue-room flag in
// tdata. Output stream (m_*): one result per item; tuser is the kind (stored
// byte, commit, dropped, bad length, garbage, overrun), tlast marks the last
// result caused by one input byte. Config port: cfg_we/cfg_index/cfg_data
// writes the min (index 0) and max (index 1) frame length limits.
// Results of an accepted byte are written into the result queue and offered
// from there. Throughput: one byte per cycle while s_tready is high; each
// byte yields zero, one or two results (implied zero plus frame status),
// and the output port delivers one result per cycle while m_tready is high.
// The figure is set by the single-pass decode step feeding a four-entry
// result queue; s_tready is low while three or more results wait.
// Reset: decoder state cleared, slot 0, drop counter 0, limits 1 and 256,
// queue empty. A stall on m_tready holds the results in the queue, and
// input stops once the queue cannot take another two.
module cobs_frame_decoder_top #(
  parameter int BUF_BYTES = cobsd_pkg::DEF_BUF_BYTES,
  parameter int NUM_SLOTS = cobsd_pkg::DEF_NUM_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cobsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cobsd_pkg::LEN_W-1:0]     cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // rx_byte, queue_has_room
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [55:0]                     m_tdata,   // slot, position, data, drop_count
  output logic [cobsd_pkg::KIND_W-1:0]    m_tuser,   // kind
  output logic                            m_tlast
);
  import cobsd_pkg::*;

  logic      in_fire;
  step_out_t step_out;
  res_t      head_res;

  assign in_fire = s_tvalid && s_tready;

  cobsd_step #(
    .BUF_BYTES(BUF_BYTES),
    .NUM_SLOTS(NUM_SLOTS)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_fire       (in_fire),
    .rx_byte       (s_tdata[7:0]),
    .queue_has_room(s_tdata[8]),
    .step_out      (step_out)
  );

  cobsd_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .step_out(step_out),
    .space_ok(s_tready),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (head_res)
  );

  // Output packing, lowest field first
  assign m_tdata = {5'b0, head_res.drop_count, head_res.data,
                    head_res.position, head_res.slot};
  assign m_tuser = head_res.kind;
  assign m_tlast = head_res.last;

endmodule

// ----- tb/sv/cobs_frame_decoder_top_tb.sv -----
module cobs_frame_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cobsd_pkg::*;

  localparam int BUF_BYTES  = DEF_BUF_BYTES;
  localparam int NUM_SLOTS  = DEF_NUM_SLOTS;
  localparam int FULL_BLOCK = 254;          // data bytes behind a 0xff code
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct {
    kind_t               kind;
    logic [SLOT_W_O-1:0] slot;
    logic [POS_W-1:0]    pos;
    logic [BYTE_W-1:0]   data;
    logic [DROP_W-1:0]   drops;
    logic                last;
  } dec_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;   // rx_byte, queue_has_room
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [55:0]          m_tdata;        // slot, position, data, drop_count
  logic [KIND_W-1:0]    m_tuser;        // kind
  logic                 m_tlast;

  // Decoder shadow state
  logic [BYTE_W-1:0] code_val   = CODE_RESTART;
  int                left_cnt   = 0;
  int                wr_pos     = 0;
  int                cur_slot   = 0;
  logic [DROP_W-1:0] drop_total = '0;
  int                lim_min    = int'(MIN_LEN_RST);
  int                lim_max    = int'(MAX_LEN_RST);

  dec_result_t pending_results[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  bit          tx_fast    = 1'b0;
  bit          rx_fast    = 1'b0;

  cobs_frame_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #6 clk = ~clk;

  // Shadow decoder
  function automatic dec_result_t make_result(kind_t k, int p, logic [BYTE_W-1:0] d);
    dec_result_t r;
    r.kind  = k;
    r.slot  = cur_slot[SLOT_W_O-1:0];
    r.pos   = p[POS_W-1:0];
    r.data  = d;
    r.drops = '0;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic void restart_decoder();
    code_val = CODE_RESTART;
    left_cnt = 0;
    wr_pos   = 0;
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] b, input bit room);
    dec_result_t step_q[$];
    int          frame_len;
    bit          implied;
    implied = 1'b0;
    // full buffer and more data: reset, then decode the byte afresh
    if (wr_pos >= BUF_BYTES && b != BYTE_ZERO) begin
      step_q.push_back(make_result(KIND_OVERRUN, wr_pos, BYTE_ZERO));
      restart_decoder();
    end
    if (left_cnt != 0) begin
      if (b == BYTE_ZERO) begin
        step_q.push_back(make_result(KIND_GARBAGE, wr_pos, BYTE_ZERO));
        restart_decoder();
      end else begin
        step_q.push_back(make_result(KIND_BYTE, wr_pos, b));
        wr_pos++;
        left_cnt--;
      end
    end else begin
      // block boundary: implied zero unless the block was a full one
      if (code_val != CODE_RESTART) begin
        if (wr_pos < BUF_BYTES)
          step_q.push_back(make_result(KIND_BYTE, wr_pos, BYTE_ZERO));
        wr_pos++;
        implied = 1'b1;
      end
      code_val = b;
      left_cnt = b;
      if (b == BYTE_ZERO) begin
        if (wr_pos != 0) begin
          frame_len = implied ? wr_pos - 1 : wr_pos;
          if (frame_len >= lim_min && frame_len <= lim_max) begin
            if (room) begin
              step_q.push_back(make_result(KIND_COMMIT, frame_len, BYTE_ZERO));
              cur_slot = (cur_slot + 1) % NUM_SLOTS;
            end else begin
              drop_total++;
              step_q.push_back(make_result(KIND_DROP, frame_len, BYTE_ZERO));
            end
          end else begin
            step_q.push_back(make_result(KIND_BAD_LEN, frame_len, BYTE_ZERO));
          end
        end
        restart_decoder();
      end else begin
        left_cnt--;
      end
    end
    foreach (step_q[i]) begin
      step_q[i].drops = drop_total;
      step_q[i].last  = (i == step_q.size() - 1);
      pending_results.push_back(step_q[i]);
    end
  endtask

  // Stimulus helpers
  function automatic logic [BYTE_W-1:0] rand_byte(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct)
      return BYTE_ZERO;
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  function automatic byte_q_t make_payload(int len, int zero_pct);
    byte_q_t p;
    repeat (len) p.push_back(rand_byte(zero_pct));
    return p;
  endfunction

  // COBS encode plus closing zero; trim drops the empty block after a full one
  function automatic byte_q_t cobs_encode(byte_q_t payload, bit trim);
    byte_q_t enc;
    byte_q_t blk;
    bit      after_full;
    after_full = 1'b0;
    foreach (payload[i]) begin
      if (payload[i] == BYTE_ZERO) begin
        enc.push_back(BYTE_W'(blk.size() + 1));
        enc = {enc, blk};
        blk.delete();
        after_full = 1'b0;
      end else begin
        blk.push_back(payload[i]);
        if (blk.size() == FULL_BLOCK) begin
          enc.push_back(CODE_RESTART);
          enc = {enc, blk};
          blk.delete();
          after_full = 1'b1;
        end
      end
    end
    if (!(trim && after_full && blk.size() == 0)) begin
      enc.push_back(BYTE_W'(blk.size() + 1));
      enc = {enc, blk};
    end
    enc.push_back(BYTE_ZERO);
    return enc;
  endfunction

  // One input item: idle gap, then hold until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit room);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, room, b};
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    predict_byte(b, room);
  endtask

  // Room flag matters on the closing zero; earlier bytes get random room
  task automatic send_frame(input byte_q_t enc, input bit room);
    foreach (enc[i])
      send_byte(enc[i], (i == enc.size() - 1) ? room : 1'($urandom_range(0, 1)));
  endtask

  // Stop sending and let every expected result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LEN_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_LEN)
      lim_min = value;
    else if (idx == REG_MAX_LEN)
      lim_max = value;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Result checker
  always @(posedge clk) begin
    dec_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", m_tuser));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(m_tuser), 32'(want.kind));
        check_field("slot", 32'(m_tdata[1:0]), 32'(want.slot));
        check_field("position", 32'(m_tdata[10:2]), 32'(want.pos));
        check_field("data", 32'(m_tdata[18:11]), 32'(want.data));
        check_field("drop_count", m_tdata[50:19], want.drops);
        check_field("last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Result sink with random stalls
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = rx_fast ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Short frames, lone zero, drop, empty frame, garbage
  task automatic test_basic_frames();
    send_byte(BYTE_ZERO, 1'b1);
    send_frame(cobs_encode('{8'h11}, 1'b0), 1'b1);
    send_frame(cobs_encode('{BYTE_ZERO}, 1'b0), 1'b1);
    send_frame(cobs_encode(make_payload(0, 0), 1'b0), 1'b1);
    send_frame(cobs_encode('{8'h80, BYTE_ZERO, 8'h7f}, 1'b0), 1'b0);
    send_frame(cobs_encode('{8'hff, 8'h01, 8'h55, 8'haa}, 1'b0), 1'b1);
    send_byte(8'h05, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(BYTE_ZERO, 1'b1);
    settle();
  endtask

  // Full blocks, phantom zero at the buffer end, overruns
  task automatic test_buffer_end();
    byte_q_t enc;
    tx_fast = 1'b1;
    send_frame(cobs_encode(make_payload(FULL_BLOCK, 0), 1'b1), 1'b1);
    tx_fast = 1'b0;
    rx_fast = 1'b1;
    send_frame(cobs_encode(make_payload(BUF_BYTES, 0), 1'b0), 1'b1);
    rx_fast = 1'b0;
    send_frame(cobs_encode(make_payload(BUF_BYTES + 1, 0), 1'b0), 1'b1);
    // full buffer at a block boundary, then a non-zero code
    enc = cobs_encode(make_payload(BUF_BYTES, 0), 1'b0);
    void'(enc.pop_back());
    enc.push_back(8'h03);
    enc.push_back(8'h42);
    enc.push_back(8'h43);
    send_frame(enc, 1'b1);
    settle();
  endtask

  // Limit pairs including extremes, inverted and unused indexes
  task automatic test_length_limits();
    int lo_q[$];
    int hi_q[$];
    int lens[$];
    lo_q = '{0, 0, 256, 10, 3, $urandom_range(0, 256)};
    hi_q = '{0, 256, 256, 5, 3, $urandom_range(0, 256)};
    foreach (lo_q[k]) begin
      write_limit(REG_MIN_LEN, lo_q[k]);
      write_limit(REG_MAX_LEN, hi_q[k]);
      lens = '{0, 1, 2, lo_q[k], hi_q[k], hi_q[k] + 1};
      foreach (lens[i])
        if (lens[i] <= BUF_BYTES)
          send_frame(cobs_encode(make_payload(lens[i], 20), 1'($urandom_range(0, 1))),
                     (i != 3));
      settle();
    end
    write_limit(REG_SPARE_A, $urandom_range(0, 256));
    write_limit(REG_SPARE_B, 255);
    write_limit(REG_MIN_LEN, int'(MIN_LEN_RST));
    write_limit(REG_MAX_LEN, int'(MAX_LEN_RST));
    send_frame(cobs_encode(make_payload(3, 20), 1'b0), 1'b1);
    settle();
  endtask

  // Mostly valid frames with random content, plus broken frames and noise
  task automatic test_random_traffic();
    byte_q_t enc;
    int      start;
    int      phase_mark;
    int      pick;
    int      len;
    int      cut;
    start      = bytes_sent;
    phase_mark = bytes_sent;
    while (bytes_sent - start < 800) begin
      if (bytes_sent - phase_mark >= 200) begin
        settle();
        if ($urandom_range(0, 3) == 0) begin
          write_limit(REG_MIN_LEN, $urandom_range(0, 256));
          write_limit(REG_MAX_LEN, $urandom_range(0, 256));
        end else begin
          write_limit(REG_MIN_LEN, $urandom_range(0, 4));
          write_limit(REG_MAX_LEN, $urandom_range(200, 256));
        end
        tx_fast    = ($urandom_range(0, 3) == 0);
        rx_fast    = ($urandom_range(0, 3) == 0);
        phase_mark = bytes_sent;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        send_frame(cobs_encode(make_payload(len, 25), 1'($urandom_range(0, 1))),
                   ($urandom_range(0, 99) < 85));
      end else if (pick < 85) begin
        // frame cut short, then closed by a zero
        enc = cobs_encode(make_payload($urandom_range(1, 12), 25), 1'b0);
        cut = $urandom_range(1, enc.size() - 1);
        enc = enc[0:cut-1];
        enc.push_back(BYTE_ZERO);
        send_frame(enc, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(rand_byte(30), 1'($urandom_range(0, 1)));
      end
    end
    settle();
  endtask

  // Main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_frames();
    test_buffer_end();
    test_length_limits();
    test_random_traffic();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
